/* design/rpa_pkg.sv */
// shared types, register codes and the cordic arctangent table of the axis rotation unit
`timescale 1ns / 1ps

package rpa_pkg;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 32;
	localparam int AtanIdxW = 5;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ANGLE    = 3'd0,
		REG_ORIGIN_X = 3'd1,
		REG_ORIGIN_Y = 3'd2,
		REG_ORIGIN_Z = 3'd3,
		REG_AXIS_X   = 3'd4,
		REG_AXIS_Y   = 3'd5,
		REG_AXIS_Z   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [31:0] rotated_x;
		logic signed [31:0] rotated_y;
		logic signed [31:0] rotated_z;
		logic               overflow;
	} result_t;

	typedef struct packed {
		logic signed [25:0] angle_deg;
		logic signed [17:0] axis_x;
		logic signed [17:0] axis_y;
		logic signed [17:0] axis_z;
	} rot_cfg_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
	} origin_t;

	typedef logic signed [31:0] coef_t;
	typedef coef_t [8:0] coef_set_t;

	typedef struct packed {
		logic      ready;
		coef_set_t coef;
	} coef_bus_t;

	// arctangent of 2^-i in degrees, 24 fractional bits
	function automatic logic signed [31:0] atan_deg_q24(input logic [AtanIdxW-1:0] idx);
		logic signed [31:0] v;
		unique case (idx)
			5'd0:  v = 32'sd754974720;
			5'd1:  v = 32'sd445687602;
			5'd2:  v = 32'sd235489088;
			5'd3:  v = 32'sd119537938;
			5'd4:  v = 32'sd60000934;
			5'd5:  v = 32'sd30029717;
			5'd6:  v = 32'sd15018523;
			5'd7:  v = 32'sd7509720;
			5'd8:  v = 32'sd3754917;
			5'd9:  v = 32'sd1877466;
			5'd10: v = 32'sd938734;
			5'd11: v = 32'sd469367;
			5'd12: v = 32'sd234683;
			5'd13: v = 32'sd117342;
			5'd14: v = 32'sd58671;
			5'd15: v = 32'sd29335;
			5'd16: v = 32'sd14668;
			5'd17: v = 32'sd7334;
			5'd18: v = 32'sd3667;
			5'd19: v = 32'sd1833;
			5'd20: v = 32'sd917;
			5'd21: v = 32'sd458;
			5'd22: v = 32'sd229;
			5'd23: v = 32'sd115;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage

/* design/rpa_coef_gen.sv */
// sequencer that reduces the angle, runs the cordic and builds the nine matrix coefficients
`timescale 1ns / 1ps

module rpa_coef_gen import rpa_pkg::*; #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      restart,
	input  rot_cfg_t  cfg,
	output coef_bus_t coef_bus
);

	localparam int IterW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
	localparam logic [IterW-1:0] LastIter = IterW'(CORDIC_ITERATIONS - 1);

	localparam logic signed [26:0] FullTurn    = 27'sd23592960;
	localparam logic signed [26:0] HalfTurn    = 27'sd11796480;
	localparam logic signed [26:0] QuarterTurn = 27'sd5898240;
	localparam logic signed [33:0] CordicGain  = 34'sd652032874;

	typedef enum logic [3:0] {
		S_MOD,
		S_WRAP,
		S_FOLD,
		S_ROT,
		S_TRIG,
		S_SINE,
		S_AA,
		S_CC,
		S_DONE
	} gen_state_t;

	gen_state_t         state_q;
	logic signed [26:0] r_q;
	logic               flip_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic [IterW-1:0]   it_q;
	logic signed [17:0] c_q, s_q;
	logic signed [18:0] cc_q;
	logic signed [19:0] sx_q, sy_q, sz_q;
	logic signed [19:0] aa_q;
	logic [1:0]         row_q, col_q;
	coef_set_t          coef_q;

	function automatic logic signed [17:0] clamp_one(input logic signed [33:0] v);
		logic signed [17:0] r;
		priority if (v > 34'sd65536) r = 18'sd65536;
		else if (v < -34'sd65536)    r = -18'sd65536;
		else                         r = 18'(v);
		return r;
	endfunction

	function automatic logic signed [17:0] pick_axis(input logic [1:0] sel, input rot_cfg_t c);
		logic signed [17:0] a;
		unique case (sel)
			2'd0:    a = c.axis_x;
			2'd1:    a = c.axis_y;
			default: a = c.axis_z;
		endcase
		return a;
	endfunction

	logic signed [26:0] ang_ext, mod_r, wrap_r, fold_r;
	logic               fold_flip;
	logic signed [33:0] x_sh, y_sh, atan_z;
	logic signed [33:0] x_rnd, y_rnd;
	logic signed [17:0] c_cl, s_cl, c_fl, s_fl;
	logic signed [18:0] cc_n;
	logic signed [35:0] psx, psy, psz, paa;
	logic signed [38:0] pcc;
	logic signed [22:0] cc_rnd;
	logic signed [31:0] term, coef_n;
	logic [3:0]         k_idx;

	// angle reduction, the remainder keeps the sign of the angle
	always_comb begin
		ang_ext = 27'(cfg.angle_deg);
		priority if (ang_ext >= FullTurn) mod_r = ang_ext - FullTurn;
		else if (ang_ext <= -FullTurn)    mod_r = ang_ext + FullTurn;
		else                              mod_r = ang_ext;
	end

	always_comb begin
		priority if (r_q >= HalfTurn) wrap_r = r_q - FullTurn;
		else if (r_q < -HalfTurn)     wrap_r = r_q + FullTurn;
		else                          wrap_r = r_q;
	end

	// fold into plus or minus a quarter turn, sine and cosine negated later
	always_comb begin
		fold_flip = 1'b1;
		priority if (r_q > QuarterTurn) fold_r = r_q - HalfTurn;
		else if (r_q < -QuarterTurn)    fold_r = r_q + HalfTurn;
		else begin
			fold_r    = r_q;
			fold_flip = 1'b0;
		end
	end

	assign x_sh   = x_q >>> it_q;
	assign y_sh   = y_q >>> it_q;
	assign atan_z = 34'(atan_deg_q24(AtanIdxW'(it_q)));

	always_comb begin
		x_rnd = (x_q + 34'sd8192) >>> 14;
		y_rnd = (y_q + 34'sd8192) >>> 14;
		c_cl  = clamp_one(x_rnd);
		s_cl  = clamp_one(y_rnd);
		c_fl  = flip_q ? -c_cl : c_cl;
		s_fl  = flip_q ? -s_cl : s_cl;
		cc_n  = 19'sd65536 - 19'(c_fl);
	end

	assign psx = 36'($signed(cfg.axis_x)) * 36'(s_q);
	assign psy = 36'($signed(cfg.axis_y)) * 36'(s_q);
	assign psz = 36'($signed(cfg.axis_z)) * 36'(s_q);
	assign paa = 36'(pick_axis(row_q, cfg)) * 36'(pick_axis(col_q, cfg));
	assign pcc = 39'(aa_q) * 39'(cc_q);

	always_comb begin
		logic signed [38:0] pcc_r;
		pcc_r  = pcc + 39'sd32768;
		cc_rnd = pcc_r[38:16];
		unique case ({row_q, col_q})
			4'b0000, 4'b0101, 4'b1010: term = 32'(c_q);
			4'b0001:                   term = -32'(sz_q);
			4'b0100:                   term = 32'(sz_q);
			4'b0010:                   term = 32'(sy_q);
			4'b1000:                   term = -32'(sy_q);
			4'b0110:                   term = -32'(sx_q);
			4'b1001:                   term = 32'(sx_q);
			default:                   term = 32'sd0;
		endcase
		coef_n = 32'(cc_rnd) + term;
		k_idx  = {1'b0, row_q, 1'b0} + {2'b00, row_q} + {2'b00, col_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_MOD;
		end else if (restart) begin
			state_q <= S_MOD;
		end else begin
			unique case (state_q)
				S_MOD: begin
					r_q     <= mod_r;
					state_q <= S_WRAP;
				end
				S_WRAP: begin
					r_q     <= wrap_r;
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					flip_q  <= fold_flip;
					z_q     <= 34'(fold_r) <<< 8;
					x_q     <= CordicGain;
					y_q     <= 34'sd0;
					it_q    <= '0;
					state_q <= S_ROT;
				end
				S_ROT: begin
					if (!z_q[33]) begin
						x_q <= x_q - y_sh;
						y_q <= y_q + x_sh;
						z_q <= z_q - atan_z;
					end else begin
						x_q <= x_q + y_sh;
						y_q <= y_q - x_sh;
						z_q <= z_q + atan_z;
					end
					it_q <= it_q + 1'b1;
					if (it_q == LastIter) state_q <= S_TRIG;
				end
				S_TRIG: begin
					c_q     <= c_fl;
					s_q     <= s_fl;
					cc_q    <= cc_n;
					state_q <= S_SINE;
				end
				S_SINE: begin
					sx_q    <= 20'((psx + 36'sd32768) >>> 16);
					sy_q    <= 20'((psy + 36'sd32768) >>> 16);
					sz_q    <= 20'((psz + 36'sd32768) >>> 16);
					row_q   <= 2'd0;
					col_q   <= 2'd0;
					state_q <= S_AA;
				end
				S_AA: begin
					aa_q    <= 20'((paa + 36'sd32768) >>> 16);
					state_q <= S_CC;
				end
				S_CC: begin
					coef_q[k_idx] <= coef_n;
					state_q       <= S_AA;
					if (col_q == 2'd2) begin
						col_q <= 2'd0;
						if (row_q == 2'd2) state_q <= S_DONE;
						else               row_q   <= row_q + 2'd1;
					end else begin
						col_q <= col_q + 2'd1;
					end
				end
				S_DONE: begin
					state_q <= S_DONE;
				end
				default: begin
					state_q <= S_MOD;
				end
			endcase
		end
	end

	assign coef_bus.ready = (state_q == S_DONE);
	assign coef_bus.coef  = coef_q;

endmodule

/* design/rpa_xform.sv */
// four stage point transform: offset, nine products, row sums, origin add and saturation
`timescale 1ns / 1ps

module rpa_xform import rpa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  coef_bus_t coef_bus,
	input  origin_t   origin,
	input  logic      point_valid,
	output logic      point_stall,
	input  point_t    point,
	output logic      result_valid,
	input  logic      result_stall,
	output result_t   result
);

	logic signed [31:0] org [3];
	logic signed [31:0] pin [3];

	logic               v_s1, v_s2, v_s3;
	logic signed [32:0] d_s1 [3];
	logic signed [64:0] prod_s2 [9];
	logic signed [50:0] row_s3 [3];
	logic               result_valid_q;
	result_t            result_q;

	logic adv_out, adv_3, adv_2, adv_1, accept;

	assign org[0] = origin.origin_x;
	assign org[1] = origin.origin_y;
	assign org[2] = origin.origin_z;
	assign pin[0] = point.point_x;
	assign pin[1] = point.point_y;
	assign pin[2] = point.point_z;

	assign adv_out     = !result_valid_q || !result_stall;
	assign adv_3       = !v_s3 || adv_out;
	assign adv_2       = !v_s2 || adv_3;
	assign adv_1       = !v_s1 || adv_2;
	assign point_stall = !coef_bus.ready || !adv_1;
	assign accept      = point_valid && !point_stall;

	logic signed [50:0] row_n [3];
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			logic signed [66:0] sum;
			sum = 67'(prod_s2[3*r]) + 67'(prod_s2[3*r+1]) + 67'(prod_s2[3*r+2])
			    + 67'sd32768;
			row_n[r] = sum[66:16];
		end
	end

	logic signed [31:0] res_n [3];
	logic [2:0]         ovf_n;
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			logic signed [51:0] v;
			v = 52'(row_s3[r]) + 52'(org[r]);
			ovf_n[r] = !((&v[51:31]) || !(|v[51:31]));
			if (!ovf_n[r])    res_n[r] = v[31:0];
			else if (v[51])   res_n[r] = 32'sh8000_0000;
			else              res_n[r] = 32'sh7fff_ffff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (adv_1)   v_s1           <= accept;
			if (adv_2)   v_s2           <= v_s1;
			if (adv_3)   v_s3           <= v_s2;
			if (adv_out) result_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_1) begin
			for (int i = 0; i < 3; i++) d_s1[i] <= 33'(pin[i]) - 33'(org[i]);
		end
		if (adv_2) begin
			for (int k = 0; k < 9; k++)
				prod_s2[k] <= 65'($signed(coef_bus.coef[k])) * 65'(d_s1[k % 3]);
		end
		if (adv_3) begin
			for (int r = 0; r < 3; r++) row_s3[r] <= row_n[r];
		end
		if (adv_out) begin
			result_q.rotated_x <= res_n[0];
			result_q.rotated_y <= res_n[1];
			result_q.rotated_z <= res_n[2];
			result_q.overflow  <= |ovf_n;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* design/rotate_point_about_axis_unit.sv */
// top level of the axis-angle point rotation unit: register file, coefficient builder, transform
`timescale 1ns / 1ps
// an accepted point request passes the offset, product, row sum and result registers to its result
// throughput is set by the transform pipeline, nine products a cycle, one request in each cycle unless stalled
// after reset and after each register write the coefficients are rebuilt (angle reduction, one
// cordic iteration a cycle, then a product step and a sum step per coefficient); point_stall
// stays high meanwhile, register writes are still taken
// arst_n low clears the registers to zero angle, zero origin and the z axis, and empties the pipe

module rotate_point_about_axis_unit import rpa_pkg::*; #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                point_valid,
	output logic                point_stall,
	input  point_t              point,
	output logic                result_valid,
	input  logic                result_stall,
	output result_t             result
);

	// configuration registers
	rot_cfg_t  rot_cfg_q;
	origin_t   origin_q;
	logic      restart;
	coef_bus_t coef_bus;

	// any write to a known register invalidates the matrix
	assign restart = cfg_wr_en && (cfg_index <= REG_AXIS_Z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_cfg_q.angle_deg <= 26'sd0;
			rot_cfg_q.axis_x    <= 18'sd0;
			rot_cfg_q.axis_y    <= 18'sd0;
			rot_cfg_q.axis_z    <= 18'sd65536;
			origin_q.origin_x   <= 32'sd0;
			origin_q.origin_y   <= 32'sd0;
			origin_q.origin_z   <= 32'sd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ANGLE:    rot_cfg_q.angle_deg <= cfg_data[25:0];
				REG_ORIGIN_X: origin_q.origin_x   <= cfg_data;
				REG_ORIGIN_Y: origin_q.origin_y   <= cfg_data;
				REG_ORIGIN_Z: origin_q.origin_z   <= cfg_data;
				REG_AXIS_X:   rot_cfg_q.axis_x    <= cfg_data[17:0];
				REG_AXIS_Y:   rot_cfg_q.axis_y    <= cfg_data[17:0];
				REG_AXIS_Z:   rot_cfg_q.axis_z    <= cfg_data[17:0];
				default: begin
					// unknown index, nothing changes
				end
			endcase
		end
	end

	// sine, cosine and the rodrigues matrix, built once per configuration
	rpa_coef_gen #(
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) u_coef_gen (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.cfg      (rot_cfg_q),
		.coef_bus (coef_bus)
	);

	// per point: offset by origin, matrix multiply, round, shift back, saturate
	rpa_xform u_xform (
		.clk          (clk),
		.arst_n       (arst_n),
		.coef_bus     (coef_bus),
		.origin       (origin_q),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.point        (point),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

/* design/rpa_checker.sv */
// port level checks for the axis rotation unit, bound to the top level
`timescale 1ns / 1ps

module rpa_checker import rpa_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_wr_en,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic               point_valid,
	input logic               point_stall,
	input logic               result_valid,
	input logic               result_stall,
	input result_t            result
);

	logic accept;
	assign accept = point_valid && !point_stall;

	// no request is taken while coming out of reset, the matrix is still being built
	a_stall_after_reset: assert property (@(posedge clk)
		!$past(arst_n) |-> point_stall)
		else $error("point request taken before coefficients were built");

	// a register write forces a rebuild, so requests must be held off
	a_stall_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr_en && (cfg_index <= REG_AXIS_Z)) |=> point_stall)
		else $error("point request not held off after register write");

	// a stalled result keeps its value
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result changed or dropped");

	// with the output free, an accepted request comes out as a valid result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(accept ##1 !result_stall ##1 !result_stall ##1 !result_stall) |=> result_valid)
		else $error("result missing four cycles after request");

endmodule

bind rotate_point_about_axis_unit rpa_checker u_rpa_checker (.*);
